FILE: design/bmhq_pkg.sv
// Package for the binary min-heap priority queue.
// Holds operation and status codes and the fixed field widths.
// No dependencies.
`default_nettype none

package bmhq_pkg;

    localparam int CNT_W = 7;    // count, index and capacity fields
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADIDX = 2'd3;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

endpackage

`default_nettype wire

FILE: design/binary_min_heap_queue.sv
// Binary min-heap priority queue. One operation at a time: an operation beat is taken only
// when the previous one has finished its heap walk and loaded its result into the output
// register, where it may still wait. Entries sit in two identical RAM banks (written
// together) so that both children of a node are read in the same cycle. A sift walks one
// heap level per compare step, then writes the carried entry and loads the result: insert
// and a change that moves up walk up, remove and a change that moves down walk down, by at
// most 6 levels for 64 entries. A remove that leaves at most one entry, a change at a leaf
// that stays put, and refused operations do no walk.
// Depends on bmhq_pkg and bmhq_ram.
`default_nettype none

module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int PRIO_WIDTH = 32,
    parameter int TAG_WIDTH  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         i_cfg_we,
    input  wire logic [CNT_W-1:0]             i_cfg_data,
    // operation channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [OP_W-1:0]              i_op,
    input  wire logic signed [PRIO_WIDTH-1:0] i_priority_req,
    input  wire logic [TAG_WIDTH-1:0]         i_tag,
    input  wire logic [CNT_W-1:0]             i_index,
    // result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [ST_W-1:0]                   o_status,
    output logic [TAG_WIDTH-1:0]              o_out_tag,
    output logic signed [PRIO_WIDTH-1:0]      o_out_priority,
    output logic [CNT_W-1:0]                  o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int EW = PRIO_WIDTH + TAG_WIDTH;
    localparam int PW = (CNT_W + 1 > AW) ? CNT_W + 1 : AW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RM_DAT = 3'd1;
    localparam logic [2:0] S_CH_DAT = 3'd2;
    localparam logic [2:0] S_UP_CMP = 3'd3;
    localparam logic [2:0] S_DN_CMP = 3'd4;
    localparam logic [2:0] S_FINAL  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // Heap positions are 1-based; position p lives at address p - 1.
    function automatic logic [AW-1:0] pos2addr(input logic [CNT_W:0] pos);
        logic [PW-1:0] t;
        t = PW'(pos) - PW'(1);
        return t[AW-1:0];
    endfunction

    // control state
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cap;
    logic             r_ovalid, n_ovalid;

    // working registers
    logic [CNT_W-1:0]            r_pos, n_pos;
    logic [CNT_W-1:0]            r_lim, n_lim;
    logic [PRIO_WIDTH-1:0]       r_cprio, n_cprio;
    logic [TAG_WIDTH-1:0]        r_ctag, n_ctag;
    logic [ST_W-1:0]             r_status, n_status;
    logic [PRIO_WIDTH-1:0]       r_oprio, n_oprio;
    logic [TAG_WIDTH-1:0]        r_otag, n_otag;

    // result register
    logic [ST_W-1:0]             r_res_status;
    logic [PRIO_WIDTH-1:0]       r_res_prio;
    logic [TAG_WIDTH-1:0]        r_res_tag;
    logic [CNT_W-1:0]            r_res_count;
    logic                        w_load;

    // memory ports
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [EW-1:0]   w_wdata;
    logic [CNT_W:0]  w_rpos_a, w_rpos_b;
    logic [EW-1:0]   w_rd_a, w_rd_b;

    logic [CNT_W-1:0] w_cap_eff;
    logic             w_accept;

    // sift helpers
    logic [PRIO_WIDTH-1:0] w_prio_a, w_prio_b;
    logic [CNT_W:0]        w_lc, w_rc, w_cpos, w_next_lc;
    logic [EW-1:0]         w_cdata;
    logic                  w_right;
    logic [CNT_W-1:0]      w_pp, w_ins_pos;

    bmhq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (pos2addr(w_rpos_a)),
        .o_rdata (w_rd_a)
    );

    bmhq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (pos2addr(w_rpos_b)),
        .o_rdata (w_rd_b)
    );

    assign w_cap_eff  = (int'(r_cap) > DEPTH) ? CNT_W'(DEPTH) : r_cap;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_load     = (r_state == S_DONE) && (!r_ovalid || !i_out_stall);

    assign w_prio_a  = w_rd_a[EW-1 -: PRIO_WIDTH];
    assign w_prio_b  = w_rd_b[EW-1 -: PRIO_WIDTH];
    assign w_lc      = {r_pos, 1'b0};
    assign w_rc      = w_lc + (CNT_W+1)'(1);
    assign w_right   = (w_rc <= {1'b0, r_lim}) && ($signed(w_prio_b) < $signed(w_prio_a));
    assign w_cpos    = w_right ? w_rc : w_lc;
    assign w_cdata   = w_right ? w_rd_b : w_rd_a;
    assign w_next_lc = {w_cpos[CNT_W-1:0], 1'b0};
    assign w_pp      = r_pos >> 1;
    assign w_ins_pos = r_count + CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_lim    = r_lim;
        n_cprio  = r_cprio;
        n_ctag   = r_ctag;
        n_status = r_status;
        n_oprio  = r_oprio;
        n_otag   = r_otag;
        n_ovalid = r_ovalid;
        w_we     = 1'b0;
        w_waddr  = pos2addr({1'b0, r_pos});
        w_wdata  = {r_cprio, r_ctag};
        w_rpos_a = {1'b0, r_pos};
        w_rpos_b = {1'b0, r_pos};

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_oprio  = '0;
                    n_otag   = '0;
                    n_cprio  = i_priority_req;
                    n_ctag   = i_tag;
                    n_state  = S_DONE;
                    case (i_op)
                        OP_INSERT: begin
                            if (r_count >= w_cap_eff) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count  = w_ins_pos;
                                n_pos    = w_ins_pos;
                                w_rpos_a = {1'b0, w_ins_pos >> 1};
                                n_state  = (w_ins_pos == CNT_W'(1)) ? S_FINAL : S_UP_CMP;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count  = r_count - CNT_W'(1);
                                n_lim    = r_count - CNT_W'(1);
                                n_pos    = CNT_W'(1);
                                w_rpos_a = (CNT_W+1)'(1);
                                w_rpos_b = {1'b0, r_count};
                                n_state  = S_RM_DAT;
                            end
                        end
                        OP_CHANGE: begin
                            if (i_index == '0 || i_index > r_count) begin
                                n_status = ST_BADIDX;
                            end else begin
                                n_pos    = i_index;
                                n_lim    = r_count;
                                w_rpos_a = {1'b0, i_index};
                                w_rpos_b = {1'b0, i_index >> 1};
                                n_state  = S_CH_DAT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_RM_DAT: begin
                // Bank A holds the root, bank B the last entry, which now sifts down.
                n_oprio = w_prio_a;
                n_otag  = w_rd_a[TAG_WIDTH-1:0];
                n_cprio = w_prio_b;
                n_ctag  = w_rd_b[TAG_WIDTH-1:0];
                if (r_lim == '0) begin
                    n_state = S_DONE;
                end else if (w_lc <= {1'b0, r_lim}) begin
                    w_rpos_a = w_lc;
                    w_rpos_b = w_rc;
                    n_state  = S_DN_CMP;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = w_rd_b;
                    n_state = S_DONE;
                end
            end

            S_CH_DAT: begin
                // Bank A holds the entry being changed, bank B its parent.
                n_ctag = w_rd_a[TAG_WIDTH-1:0];
                if (r_pos > CNT_W'(1) && $signed(r_cprio) < $signed(w_prio_b)) begin
                    w_we     = 1'b1;
                    w_wdata  = w_rd_b;
                    n_pos    = w_pp;
                    w_rpos_a = {1'b0, w_pp >> 1};
                    n_state  = (w_pp > CNT_W'(1)) ? S_UP_CMP : S_FINAL;
                end else if (w_lc <= {1'b0, r_lim}) begin
                    w_rpos_a = w_lc;
                    w_rpos_b = w_rc;
                    n_state  = S_DN_CMP;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = {r_cprio, w_rd_a[TAG_WIDTH-1:0]};
                    n_state = S_DONE;
                end
            end

            S_UP_CMP: begin
                // Bank A holds the parent of the hole at r_pos.
                w_we = 1'b1;
                if ($signed(w_prio_a) > $signed(r_cprio)) begin
                    w_wdata  = w_rd_a;
                    n_pos    = w_pp;
                    w_rpos_a = {1'b0, w_pp >> 1};
                    n_state  = (w_pp > CNT_W'(1)) ? S_UP_CMP : S_FINAL;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DN_CMP: begin
                // Both children of the hole are on the bank outputs.
                w_we = 1'b1;
                if ($signed(w_cdata[EW-1 -: PRIO_WIDTH]) < $signed(r_cprio)) begin
                    w_wdata  = w_cdata;
                    n_pos    = w_cpos[CNT_W-1:0];
                    w_rpos_a = w_next_lc;
                    w_rpos_b = w_next_lc + (CNT_W+1)'(1);
                    n_state  = (w_next_lc <= {1'b0, r_lim}) ? S_DN_CMP : S_FINAL;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_FINAL: begin
                w_we    = 1'b1;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cap    <= CAP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_lim    <= n_lim;
        r_cprio  <= n_cprio;
        r_ctag   <= n_ctag;
        r_status <= n_status;
        r_oprio  <= n_oprio;
        r_otag   <= n_otag;
        if (w_load) begin
            r_res_status <= r_status;
            r_res_prio   <= r_oprio;
            r_res_tag    <= r_otag;
            r_res_count  <= r_count;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_res_status;
    assign o_out_tag      = r_res_tag;
    assign o_out_priority = r_res_prio;
    assign o_count        = r_res_count;

endmodule

`default_nettype wire

FILE: design/bmhq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the heap entry banks. No dependencies.
`default_nettype none

module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
